/* rtl/bvg_pkg.sv */
// Shared constants, codes and control structs for the battery voltage gauge.
`timescale 1ns / 1ps
`default_nettype none

package bvg_pkg;

    localparam int PIN_W   = 12;
    localparam int MV_W    = 13;
    localparam int PCT_W   = 7;
    localparam int LVL_W   = 3;
    localparam int CS_W    = 2;
    localparam int MIN_W   = 24;
    localparam int RATE_W  = 18;
    localparam int HCNT_W  = 2;
    localparam int CIDX_W  = 2;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    localparam int RATE_FRAC_DEFAULT = 4;

    localparam logic [MV_W-1:0]   FULL_MV_RESET  = 13'd4200;
    localparam logic [MV_W-1:0]   EMPTY_MV_RESET = 13'd3200;
    localparam logic [RATE_W-1:0] RATE_MAX       = 18'h3FFFF;
    localparam logic [MIN_W-1:0]  MIN_MAX        = 24'hFFFFFF;
    localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
    localparam logic [HCNT_W-1:0] HCNT_SAT       = 2'd2;

    // register indexes on the config port
    localparam logic [CIDX_W-1:0] REG_FULL_MV     = 2'd0;
    localparam logic [CIDX_W-1:0] REG_EMPTY_MV    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_STBY_PRESENT = 2'd2;

    // charge state codes
    localparam logic [CS_W-1:0] CS_DISCHG = 2'd0;
    localparam logic [CS_W-1:0] CS_CHG    = 2'd1;
    localparam logic [CS_W-1:0] CS_FULL   = 2'd2;

    // battery level codes
    localparam logic [LVL_W-1:0] LVL_CRIT = 3'd0;
    localparam logic [LVL_W-1:0] LVL_LOW  = 3'd1;
    localparam logic [LVL_W-1:0] LVL_MED  = 3'd2;
    localparam logic [LVL_W-1:0] LVL_GOOD = 3'd3;
    localparam logic [LVL_W-1:0] LVL_FULL = 3'd4;

    // datapath operations, one per arithmetic slot
    localparam logic [1:0] OP_PCT = 2'd0;
    localparam logic [1:0] OP_AVG = 2'd1;
    localparam logic [1:0] OP_MIN = 2'd2;

    typedef struct packed {
        logic       load;      // capture input beat
        logic       resolve;   // settle op, start divider if needed
        logic       finish;    // write divider quotient for op
        logic [1:0] op;
        logic       out_load;  // move results into output register
    } bvg_cmd_t;

    typedef struct packed {
        logic need;      // current op needs the divider
        logic div_busy;
        logic div_done;
        logic out_free;  // output register can take a result
    } bvg_stat_t;

endpackage

`default_nettype wire

/* rtl/bvg_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bvg_div #(
    parameter int DVD_W = 23,
    parameter int DSR_W = 18
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DSR_W:0]   rem_shift;
    logic [DSR_W:0]   rem_diff;
    logic             ge;
    logic [DSR_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        ge        = rem_shift >= {1'b0, dsr_reg};
        rem_next  = ge ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
        quo_next  = {quo_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/bvg_ctrl.sv */
// Sequencer: walks percent, hourly update and minutes in turn, waiting on each arithmetic slot.
`timescale 1ns / 1ps
`default_nettype none

module bvg_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire bvg_pkg::bvg_stat_t stat,
    output bvg_pkg::bvg_cmd_t      cmd
);

    import bvg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PCT    = 3'd1;
    localparam logic [2:0] ST_PCT_W  = 3'd2;
    localparam logic [2:0] ST_HOUR   = 3'd3;
    localparam logic [2:0] ST_HOUR_W = 3'd4;
    localparam logic [2:0] ST_MIN    = 3'd5;
    localparam logic [2:0] ST_MIN_W  = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.op       = OP_PCT;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PCT;
                end
            end
            ST_PCT: begin
                cmd.resolve = 1'b1;
                cmd.op      = OP_PCT;
                state_next  = stat.need ? ST_PCT_W : ST_HOUR;
            end
            ST_PCT_W: begin
                cmd.op = OP_PCT;
                if (stat.div_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                cmd.resolve = 1'b1;
                cmd.op      = OP_AVG;
                state_next  = stat.need ? ST_HOUR_W : ST_MIN;
            end
            ST_HOUR_W: begin
                cmd.op = OP_AVG;
                if (stat.div_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                cmd.resolve = 1'b1;
                cmd.op      = OP_MIN;
                state_next  = stat.need ? ST_MIN_W : ST_OUT;
            end
            ST_MIN_W: begin
                cmd.op = OP_MIN;
                if (stat.div_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

/* rtl/bvg_datapath.sv */
// Datapath: config, sample and history registers, operand muxes, output register.
`timescale 1ns / 1ps
`default_nettype none

module bvg_datapath #(
    parameter int RATE_FRACTION_BITS = 4
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [bvg_pkg::CIDX_W-1:0]       cfg_index,
    input  wire logic [bvg_pkg::MV_W-1:0]         cfg_data,
    input  wire logic [bvg_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                             s_tuser,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic [bvg_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire bvg_pkg::bvg_cmd_t                cmd,
    output bvg_pkg::bvg_stat_t                    stat
);

    import bvg_pkg::*;

    localparam int PNUM_W = MV_W + PCT_W;              // (mv - empty) * 100
    localparam int ANUM_W = RATE_W + 4;                // 7*s + 3*d + 5
    localparam int MNUM_W = MV_W + 6 + RATE_FRACTION_BITS; // (mv - empty) * 60 << F
    localparam int DVD_W  = (MNUM_W > PNUM_W) ? MNUM_W : PNUM_W;
    localparam int DXW    = (MV_W + RATE_FRACTION_BITS > RATE_W) ?
                            (MV_W + RATE_FRACTION_BITS) : RATE_W;
    localparam int QXW    = (DVD_W > MIN_W) ? DVD_W : MIN_W;
    // floor(x / 10) as (x * ceil(2^25 / 10)) >> 25, exact for x < 2^22
    localparam int APROD_W   = 2 * ANUM_W;
    localparam int AVG_SHIFT = 25;
    localparam logic [ANUM_W-1:0] AVG_RECIP = ANUM_W'(3355444);

    // configuration
    logic [MV_W-1:0] full_mv_reg;
    logic [MV_W-1:0] empty_mv_reg;
    logic            stby_present_reg;

    // current sample
    logic [MV_W-1:0] mv_reg;
    logic [CS_W-1:0] cs_reg;
    logic            tick_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [MIN_W-1:0] min_reg;

    // history
    logic [MV_W-1:0]   last_hour_reg;
    logic [HCNT_W-1:0] hcnt_reg;
    logic [RATE_W-1:0] rate_reg;

    // hourly average numerator, held for the multiply cycle
    logic [ANUM_W-1:0] avg_num_reg;
    logic              avg_done_reg;

    // output beat
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [CS_W-1:0]   cs_in;
    logic [MV_W-1:0]   pdiff;
    logic [MV_W-1:0]   hdiff;
    logic [DXW-1:0]    d_ext;
    logic [RATE_W-1:0] d_sat;
    logic [ANUM_W-1:0] avg_num;
    logic [APROD_W-1:0] avg_prod;
    logic [RATE_W-1:0] avg_q;
    logic [PNUM_W-1:0] pct_num;
    logic [MNUM_W-1:0] min_num;
    logic              pct_need;
    logic              avg_cond;
    logic              avg_need;
    logic              min_need;
    logic [DVD_W-1:0]  dvd;
    logic [RATE_W-1:0] dsr;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DVD_W-1:0]  quo;
    logic [QXW-1:0]    quo_ext;
    logic [MIN_W-1:0]  min_sat;
    logic [LVL_W-1:0]  level;

    always_comb begin
        if (!s_tdata[PIN_W]) begin
            cs_in = CS_CHG;
        end else if (stby_present_reg && !s_tdata[PIN_W+1]) begin
            cs_in = CS_FULL;
        end else begin
            cs_in = CS_DISCHG;
        end
    end

    always_comb begin
        pdiff    = mv_reg - empty_mv_reg;
        hdiff    = last_hour_reg - mv_reg;
        d_ext    = DXW'(hdiff) << RATE_FRACTION_BITS;
        d_sat    = (d_ext > DXW'(RATE_MAX)) ? RATE_MAX : d_ext[RATE_W-1:0];
        avg_num  = (ANUM_W'(rate_reg) << 3) - ANUM_W'(rate_reg)
                 + (ANUM_W'(d_sat) << 1) + ANUM_W'(d_sat) + ANUM_W'(5);
        avg_prod = APROD_W'(avg_num_reg) * APROD_W'(AVG_RECIP);
        avg_q    = avg_prod[AVG_SHIFT +: RATE_W];
        pct_num  = PNUM_W'(pdiff) * PNUM_W'(PCT_FULL);
        min_num  = (MNUM_W'(pdiff) * MNUM_W'(60)) << RATE_FRACTION_BITS;

        pct_need = (mv_reg < full_mv_reg) && (mv_reg > empty_mv_reg);
        avg_cond = tick_reg && (cs_reg == CS_DISCHG) && (hcnt_reg != '0)
                 && (last_hour_reg != '0) && (mv_reg < last_hour_reg);
        avg_need = avg_cond && (rate_reg != '0);
        // minutes use the rate after any hourly update of this sample
        min_need = (rate_reg != '0) && (cs_reg == CS_DISCHG) && (mv_reg > empty_mv_reg);

        case (cmd.op)
            OP_PCT: begin
                stat.need = pct_need;
                dvd       = DVD_W'(pct_num);
                dsr       = RATE_W'(full_mv_reg - empty_mv_reg);
            end
            OP_AVG: begin
                stat.need = avg_need;
                dvd       = '0;
                dsr       = '0;
            end
            OP_MIN: begin
                stat.need = min_need;
                dvd       = DVD_W'(min_num);
                dsr       = rate_reg;
            end
            default: begin
                stat.need = 1'b0;
                dvd       = '0;
                dsr       = '0;
            end
        endcase

        // the hourly average uses the reciprocal multiply, not the divider
        div_start     = cmd.resolve && stat.need && (cmd.op != OP_AVG);
        stat.div_busy = div_busy;
        stat.div_done = div_done || avg_done_reg;
        stat.out_free = !m_valid_reg || m_tready;

        quo_ext = QXW'(quo);
        min_sat = (quo_ext > QXW'(MIN_MAX)) ? MIN_MAX : quo_ext[MIN_W-1:0];

        if (pct_reg < PCT_W'(10)) begin
            level = LVL_CRIT;
        end else if (pct_reg < PCT_W'(20)) begin
            level = LVL_LOW;
        end else if (pct_reg < PCT_W'(50)) begin
            level = LVL_MED;
        end else if (pct_reg < PCT_W'(80)) begin
            level = LVL_GOOD;
        end else begin
            level = LVL_FULL;
        end
    end

    bvg_div #(
        .DVD_W (DVD_W),
        .DSR_W (RATE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    // config and history state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_mv_reg      <= FULL_MV_RESET;
            empty_mv_reg     <= EMPTY_MV_RESET;
            stby_present_reg <= 1'b1;
            last_hour_reg    <= '0;
            hcnt_reg         <= '0;
            rate_reg         <= '0;
            avg_done_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FULL_MV:      full_mv_reg      <= cfg_data;
                    REG_EMPTY_MV:     empty_mv_reg     <= cfg_data;
                    REG_STBY_PRESENT: stby_present_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            avg_done_reg <= cmd.resolve && (cmd.op == OP_AVG) && avg_need;
            if (cmd.resolve && cmd.op == OP_AVG && tick_reg) begin
                last_hour_reg <= mv_reg;
                if (hcnt_reg != HCNT_SAT) begin
                    hcnt_reg <= hcnt_reg + 1'b1;
                end
                // first measured drop seeds the average
                if (avg_cond && rate_reg == '0) begin
                    rate_reg <= d_sat;
                end
            end
            if (cmd.finish && cmd.op == OP_AVG) begin
                rate_reg <= avg_q;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-sample payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mv_reg   <= {s_tdata[PIN_W-1:0], 1'b0};
            cs_reg   <= cs_in;
            tick_reg <= s_tuser;
        end
        if (cmd.resolve && cmd.op == OP_PCT) begin
            pct_reg <= (mv_reg >= full_mv_reg) ? PCT_FULL : '0;
        end
        if (cmd.resolve && cmd.op == OP_AVG) begin
            avg_num_reg <= avg_num;
        end
        if (cmd.resolve && cmd.op == OP_MIN) begin
            min_reg <= '0;
        end
        if (cmd.finish && cmd.op == OP_PCT) begin
            pct_reg <= quo[PCT_W-1:0];
        end
        if (cmd.finish && cmd.op == OP_MIN) begin
            min_reg <= min_sat;
        end
        if (cmd.out_load) begin
            m_data_reg <= M_TDATA_W'({min_reg, cs_reg, level, pct_reg, mv_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/battery_voltage_gauge.sv */
// Battery fuel gauge from divider-tap voltage: percent, level, charge state, minutes left.
//
// Input beats (s_*) carry one monitor sample; each gives exactly one result beat (m_*).
// Configuration: cfg_we writes cfg_data to register cfg_index (0 full_mv, 1 empty_mv,
// 2 standby_pin_present) at the clock edge; write only while no sample is in flight.
// Each sample runs through three slots: percent, hourly rate average and minutes left.
// Percent and minutes share one restoring divider that yields one quotient bit per
// cycle (D = 19 + RATE_FRACTION_BITS, at least 20, bits); the hourly average divides
// by ten with a reciprocal multiply. A slot with nothing to compute is settled in its
// resolve state, the average waits on its registered numerator and a divider slot on
// the divider's done. One sample is in flight at a time: no new beat is taken until
// the result is loaded into the output register.
// The output register frees the input side: s_tready rises as soon as the result
// is loaded, even while m_tvalid waits on m_tready. A stalled receiver holds the
// sequencer only when a new result is ready and the old one is still untaken.
// Reset (aresetn low, synchronous) restores full 4200 mV, empty 3200 mV, standby
// pin present, and clears the hourly history and smoothed rate.
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_gauge #(
    parameter int RATE_FRACTION_BITS = bvg_pkg::RATE_FRAC_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [bvg_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [bvg_pkg::MV_W-1:0]      cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [11:0] pin_mv, [12] charge_pin_n, [13] standby_pin_n, [15:14] zero
    input  wire logic [bvg_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] hour_tick
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [12:0] battery_mv, [19:13] percent, [22:20] battery_level,
    // [24:23] charge_state, [48:25] remaining_minutes, [55:49] zero
    output logic [bvg_pkg::M_TDATA_W-1:0]      m_tdata
);

    import bvg_pkg::*;

    bvg_cmd_t  cmd;
    bvg_stat_t stat;

    bvg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bvg_datapath #(
        .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // every quotient the datapath produces is consumed by the sequencer
    a_div_done_used: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> cmd.finish)
        else $error("divider result dropped");

    // no new sample enters while a division is running
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !stat.div_busy)
        else $error("sample accepted during division");

    // percent field never exceeds 100
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:13] <= 7'd100))
        else $error("percent out of range");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for battery_voltage_gauge: directed table, then random discharge runs.
`timescale 1ns / 1ps

module tb_top;
    import bvg_pkg::*;

    localparam int RATE_FRAC = RATE_FRAC_DEFAULT;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int MAX_PRINTS = 100;
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic [PCT_W-1:0] percent;
        logic [LVL_W-1:0] level;
        logic [CS_W-1:0]  charge_state;
        logic [MIN_W-1:0] minutes;
    } gauge_reading_t;

    typedef enum {ROW_SAMPLE, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [PIN_W-1:0]  pin;
        logic              chg_n;
        logic              stb_n;
        logic              tick;
        logic [CIDX_W-1:0] reg_idx;
        logic [MV_W-1:0]   reg_val;
        bit                checked;
        gauge_reading_t    want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [MV_W-1:0]       cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // gauge model state and register copies
    logic [MV_W-1:0]   full_cfg = FULL_MV_RESET;
    logic [MV_W-1:0]   empty_cfg = EMPTY_MV_RESET;
    logic              stby_cfg = 1'b1;
    logic [MV_W-1:0]   last_hour_mv = '0;
    logic [HCNT_W-1:0] hour_ticks = '0;
    logic [RATE_W-1:0] drop_rate = '0;

    gauge_reading_t pending_readings[$];
    dir_row_t       dir_rows[$];
    int             err_count = 0;
    int             cycle_count = 0;
    bit             quiet = 1'b0;

    battery_voltage_gauge #(
        .RATE_FRACTION_BITS(RATE_FRAC)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic gauge_reading_t predict_reading(logic [PIN_W-1:0] pin, logic chg_n,
                                                       logic stb_n, logic tick);
        int unsigned     mv;
        int unsigned     pct;
        int unsigned     d;
        int unsigned     avg;
        longint unsigned num;
        longint unsigned mins;
        bit              had_prev;
        gauge_reading_t  r;
        mv = {pin, 1'b0};
        if (mv >= full_cfg) pct = 100;
        else if (mv <= empty_cfg) pct = 0;
        else pct = (mv - empty_cfg) * 100 / (full_cfg - empty_cfg);
        r.battery_mv = mv;
        r.percent = pct;
        if (pct < 10) r.level = LVL_CRIT;
        else if (pct < 20) r.level = LVL_LOW;
        else if (pct < 50) r.level = LVL_MED;
        else if (pct < 80) r.level = LVL_GOOD;
        else r.level = LVL_FULL;
        if (!chg_n) r.charge_state = CS_CHG;
        else if (stby_cfg && !stb_n) r.charge_state = CS_FULL;
        else r.charge_state = CS_DISCHG;
        if (tick) begin
            had_prev = (hour_ticks >= 1);
            if (hour_ticks < HCNT_SAT) hour_ticks = hour_ticks + 1'b1;
            // drop measured against the previous hourly entry
            if (r.charge_state == CS_DISCHG && had_prev && last_hour_mv != 0
                    && mv < last_hour_mv) begin
                d = (last_hour_mv - mv) << RATE_FRAC;
                if (d > RATE_MAX) d = RATE_MAX;
                if (drop_rate == 0) begin
                    drop_rate = d;
                end else begin
                    avg = (7 * drop_rate + 3 * d + 5) / 10;
                    if (avg > RATE_MAX) avg = RATE_MAX;
                    drop_rate = avg;
                end
            end
            last_hour_mv = mv;
        end
        mins = 0;
        if (drop_rate != 0 && r.charge_state == CS_DISCHG && mv > empty_cfg) begin
            num = (longint'(mv - empty_cfg) * 60) << RATE_FRAC;
            mins = num / drop_rate;
            if (mins > MIN_MAX) mins = MIN_MAX;
        end
        r.minutes = mins;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(string name, longint unsigned got, longint unsigned want);
        if (got != want) report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    // result side: compare every accepted beat with the oldest pending reading
    always @(posedge aclk) begin
        gauge_reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", m_tdata));
            end else begin
                want = pending_readings.pop_front();
                check_field("battery_mv", m_tdata[12:0], want.battery_mv);
                check_field("percent", m_tdata[19:13], want.percent);
                check_field("battery_level", m_tdata[22:20], want.level);
                check_field("charge_state", m_tdata[24:23], want.charge_state);
                check_field("remaining_minutes", m_tdata[48:25], want.minutes);
                check_field("padding", m_tdata[55:49], 0);
            end
        end
    end

    // receiver backpressure in bursts; always ready once quiet
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            hold = 1;
            if (quiet) begin
                m_tready = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                m_tready = 1'b1;
                hold = $urandom_range(1, 12);
            end else begin
                m_tready = 1'b0;
                hold = $urandom_range(1, 12);
            end
            repeat (hold - 1) @(negedge aclk);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_sample(logic [PIN_W-1:0] pin, logic chg_n, logic stb_n, logic tick,
                               logic [1:0] pad, bit checked, gauge_reading_t want);
        gauge_reading_t r;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {pad, stb_n, chg_n, pin};
        s_tuser = tick;
        do @(posedge aclk); while (!s_tready);
        r = predict_reading(pin, chg_n, stb_n, tick);
        pending_readings.push_back(checked ? want : r);
    endtask

    // hold off the sender until every pending result has been taken
    task automatic drain_gauge();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [MV_W-1:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            REG_FULL_MV: full_cfg = val;
            REG_EMPTY_MV: empty_cfg = val;
            REG_STBY_PRESENT: stby_cfg = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic dir_sample(logic [PIN_W-1:0] pin, logic chg_n, logic stb_n, logic tick);
        dir_row_t row;
        row.kind = ROW_SAMPLE;
        row.pin = pin;
        row.chg_n = chg_n;
        row.stb_n = stb_n;
        row.tick = tick;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.checked = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endtask

    task automatic dir_checked(logic [PIN_W-1:0] pin, logic chg_n, logic stb_n, logic tick,
                               int unsigned mv, int unsigned pct, logic [LVL_W-1:0] lvl,
                               logic [CS_W-1:0] cs, int unsigned mins);
        dir_sample(pin, chg_n, stb_n, tick);
        dir_rows[$].checked = 1'b1;
        dir_rows[$].want = '{mv, pct, lvl, cs, mins};
    endtask

    task automatic dir_reg(logic [CIDX_W-1:0] idx, logic [MV_W-1:0] val);
        dir_sample('0, 1'b1, 1'b1, 1'b0);
        dir_rows[$].kind = ROW_REG;
        dir_rows[$].reg_idx = idx;
        dir_rows[$].reg_val = val;
    endtask

    int unsigned ph_full[7]  = '{4200, 8191, 0, 0, 0, 3300, 4000};
    int unsigned ph_empty[7] = '{3200, 0, 8191, 0, 0, 3299, 3000};
    int unsigned ph_stby[7]  = '{1, 0, 1, 0, 0, 1, 1};
    int unsigned ph_items[7] = '{250, 180, 120, 220, 120, 120, 240};

    initial begin
        int               i;
        int               ph;
        int               sent;
        int               run_len;
        int unsigned      lo;
        int unsigned      hi;
        logic [PIN_W-1:0] pin_lvl;
        logic [PIN_W-1:0] step;
        gauge_reading_t   none;

        none = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values and field extremes
        dir_checked(0, 1, 1, 0, 0, 0, LVL_CRIT, CS_DISCHG, 0);
        dir_checked(4095, 1, 1, 0, 8190, 100, LVL_FULL, CS_DISCHG, 0);
        dir_checked(4095, 0, 0, 0, 8190, 100, LVL_FULL, CS_CHG, 0);     // charging wins
        dir_checked(2100, 1, 0, 0, 4200, 100, LVL_FULL, CS_FULL, 0);
        dir_checked(1600, 1, 1, 0, 3200, 0, LVL_CRIT, CS_DISCHG, 0);    // exactly empty
        dir_sample(1601, 1, 1, 0);
        dir_checked(1650, 1, 1, 0, 3300, 10, LVL_LOW, CS_DISCHG, 0);
        dir_sample(1849, 1, 1, 0);
        dir_sample(2099, 1, 1, 0);
        // hourly history: first entry, seed, average, then the no-update cases
        dir_checked(2000, 1, 1, 1, 4000, 80, LVL_FULL, CS_DISCHG, 0);
        dir_sample(1990, 1, 1, 1);
        dir_sample(1980, 1, 1, 0);
        dir_sample(1970, 1, 1, 1);
        dir_sample(1960, 0, 1, 1);
        dir_sample(1970, 1, 1, 1);
        dir_sample(1960, 1, 0, 1);
        dir_checked(1500, 1, 1, 0, 3000, 0, LVL_CRIT, CS_DISCHG, 0);
        dir_checked(0, 1, 1, 1, 0, 0, LVL_CRIT, CS_DISCHG, 0);
        dir_sample(4095, 1, 1, 1);
        dir_checked(0, 1, 1, 1, 0, 0, LVL_CRIT, CS_DISCHG, 0);
        // standby pin not wired: upper data bits must be ignored
        dir_reg(REG_STBY_PRESENT, 13'h1FFE);
        dir_checked(0, 1, 0, 0, 0, 0, LVL_CRIT, CS_DISCHG, 0);
        dir_reg(REG_UNUSED, 13'h1FFF);
        dir_reg(REG_FULL_MV, 0);
        dir_checked(0, 1, 1, 0, 0, 100, LVL_FULL, CS_DISCHG, 0);
        dir_reg(REG_EMPTY_MV, 8191);
        dir_checked(4095, 0, 1, 0, 8190, 100, LVL_FULL, CS_CHG, 0);
        dir_reg(REG_FULL_MV, 8191);
        dir_reg(REG_EMPTY_MV, 0);
        dir_reg(REG_STBY_PRESENT, 1);
        dir_sample(4095, 1, 1, 0);
        dir_sample(1, 1, 1, 1);

        for (i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].kind == ROW_REG) begin
                drain_gauge();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_sample(dir_rows[i].pin, dir_rows[i].chg_n, dir_rows[i].stb_n,
                            dir_rows[i].tick, 2'b00, dir_rows[i].checked, dir_rows[i].want);
            end
        end

        for (ph = 0; ph < 7; ph++) begin
            if (ph == 3) begin
                ph_empty[ph] = $urandom_range(2000, 3600);
                ph_full[ph] = ph_empty[ph] + $urandom_range(1, 2000);
                ph_stby[ph] = $urandom_range(0, 1);
            end else if (ph == 4) begin
                ph_empty[ph] = $urandom_range(0, 8191);
                ph_full[ph] = $urandom_range(0, 8191);
                ph_stby[ph] = $urandom_range(0, 1);
            end
            drain_gauge();
            quiet = (ph == 6);
            write_reg(REG_FULL_MV, ph_full[ph]);
            write_reg(REG_EMPTY_MV, ph_empty[ph]);
            write_reg(REG_STBY_PRESENT, {12'($urandom), 1'(ph_stby[ph])});
            sent = 0;
            while (sent < ph_items[ph]) begin
                if ($urandom_range(0, 9) < 7) begin
                    // slow discharge with hourly ticks, mostly on battery
                    lo = ph_empty[ph] >> 1;
                    hi = ph_full[ph] >> 1;
                    if (hi > lo && $urandom_range(0, 3) != 0) pin_lvl = $urandom_range(lo, hi);
                    else pin_lvl = $urandom_range(0, 4095);
                    run_len = $urandom_range(5, 30);
                    while (run_len > 0 && sent < ph_items[ph]) begin
                        step = $urandom_range(0, 12);
                        pin_lvl = (pin_lvl > step) ? pin_lvl - step : '0;
                        send_sample(pin_lvl, $urandom_range(0, 9) != 0,
                                    $urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0,
                                    2'b00, 1'b0, none);
                        run_len--;
                        sent++;
                    end
                end else begin
                    send_sample($urandom_range(0, 4095), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 3), 1'b0, none);
                    sent++;
                end
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (err_count == 0 && pending_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bvg_pkg.sv
rtl/bvg_div.sv
rtl/bvg_ctrl.sv
rtl/bvg_datapath.sv
rtl/battery_voltage_gauge.sv
tb/tb_top.sv
